// File: rtl/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg: shared types and constants of the ROM read patch device
// Bus access kinds, address map bounds and the registered access record.
// ----------------------------------------------------------------------------
package rrp_pkg;

	typedef enum logic [1:0] {
		ACT_CPU_READ  = 2'd0,
		ACT_CPU_WRITE = 2'd1,
		ACT_PPU_READ  = 2'd2
	} action_t;

	localparam logic [15:0] PRG_BASE      = 16'h8000;
	localparam logic [15:0] PATTERN_LIMIT = 16'h2000;
	localparam logic [15:0] AND_BASE      = 16'hC020;
	localparam logic [11:0] CTRL_OFFSET   = 12'h000;
	localparam int          CTRL_ENTRIES  = 3;

	typedef struct packed {
		logic        low_region_readable;
		logic [7:0]  low_region_data;
		logic [7:0]  menu_rom_data;
		logic [7:0]  cart_data;
		logic [7:0]  write_data;
		logic [15:0] address;
		action_t     action;
	} item_t;

endpackage

// File: rtl/rom_read_patch_device.sv
// ----------------------------------------------------------------------------
// rom_read_patch_device: pass-through cheat device between CPU and cartridge
// Menu mode loads patch entries; game mode patches CPU reads at 0x8000 and above.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries one bus access per transfer: the kind of access
//   in s_tuser and the address and the bytes seen on the buses in s_tdata.
//   Master stream (m_*) returns one result per access: the byte for the CPU
//   or PPU, whether the access goes to the cartridge, and the mode after it.
//   An access passes through one input register, then the decode, the patch
//   entry chain and the menu register update feed the result register. One
//   access is taken every cycle while the result side does not stall; the
//   entries are compared in the same cycle, so the rate is fixed by nothing
//   but the output handshake.
//   Reset puts the device in menu mode with all entries disabled and their
//   addresses at 0xFFFF. If the receiver stalls, the result register holds,
//   the input register fills, and then s_tready drops until m_tready returns.
//   Menu writes take effect for the access that follows them.
module rom_read_patch_device #(
	parameter int NUM_ENTRIES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [48] low_region_readable, [47:40] low_region_data, [39:32] menu_rom_data,
	// [31:24] cart_data, [23:16] write_data, [15:0] address, [55:49] zero
	input  logic [55:0] s_tdata,
	// [1:0] action
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [9] in_game_mode, [8] forward_write, [7:0] read_data, [15:10] zero
	output logic [15:0] m_tdata
);

	localparam logic [11:0] MaxOffset = 12'(4 * NUM_ENTRIES);

	rrp_pkg::item_t item_s1;
	logic           valid_s1;
	logic           out_valid_q;
	logic [7:0]     read_data_q;
	logic           forward_q;
	logic           mode_q;

	logic                   game_q;
	logic [NUM_ENTRIES-1:0] enable_q;
	logic [NUM_ENTRIES-1:0] compare_q;
	logic [15:0]            addr_q  [NUM_ENTRIES];
	logic [7:0]             cmpb_q  [NUM_ENTRIES];
	logic [7:0]             repb_q  [NUM_ENTRIES];

	logic       stage_free;
	logic       advance;
	logic       menu_wr;
	logic       ctrl_wr;
	logic       game_d;
	logic [11:0] offset;
	logic [11:0] offset_m1;
	logic [7:0] pattern;
	logic [7:0] patched;
	logic [7:0] rd_d;
	logic       fwd_d;

	assign stage_free = !out_valid_q || m_tready;
	assign advance    = valid_s1 && stage_free;
	assign s_tready   = !valid_s1 || stage_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.action              <= rrp_pkg::action_t'(s_tuser);
			item_s1.address             <= s_tdata[15:0];
			item_s1.write_data          <= s_tdata[23:16];
			item_s1.cart_data           <= s_tdata[31:24];
			item_s1.menu_rom_data       <= s_tdata[39:32];
			item_s1.low_region_data     <= s_tdata[47:40];
			item_s1.low_region_readable <= s_tdata[48];
		end
	end

	assign offset    = item_s1.address[11:0];
	assign offset_m1 = offset - 12'd1;
	assign menu_wr   = item_s1.action == rrp_pkg::ACT_CPU_WRITE && !game_q
		&& item_s1.address >= rrp_pkg::PRG_BASE;
	assign ctrl_wr   = menu_wr && offset == rrp_pkg::CTRL_OFFSET;
	assign game_d    = ctrl_wr ? item_s1.write_data[0] : game_q;

	// 2-bit pattern from the tile address bits
	always_comb begin
		logic hi;
		logic lo;
		hi = item_s1.address[2] ? item_s1.address[4] : item_s1.address[6];
		lo = item_s1.address[2] ? item_s1.address[5] : item_s1.address[7];
		pattern = {{4{hi}}, {4{lo}}};
	end

	// entries chain in order: a later entry sees the value an earlier one left
	always_comb begin
		logic [7:0] v;
		v = item_s1.cart_data;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			if (enable_q[i] && addr_q[i] == item_s1.address
				&& (!compare_q[i] || v == cmpb_q[i])) begin
				v = repb_q[i];
				if (item_s1.address >= rrp_pkg::AND_BASE && item_s1.low_region_readable)
					v = v & item_s1.low_region_data;
			end
		end
		patched = v;
	end

	always_comb begin
		rd_d  = 8'd0;
		fwd_d = 1'b0;
		case (item_s1.action)
			rrp_pkg::ACT_CPU_READ: begin
				if (item_s1.address < rrp_pkg::PRG_BASE) begin
					rd_d  = item_s1.cart_data;
					fwd_d = 1'b1;
				end else if (!game_q) begin
					rd_d  = item_s1.menu_rom_data;
				end else begin
					rd_d  = patched;
					fwd_d = 1'b1;
				end
			end
			rrp_pkg::ACT_CPU_WRITE: begin
				fwd_d = !menu_wr;
			end
			rrp_pkg::ACT_PPU_READ: begin
				if (!game_q && item_s1.address < rrp_pkg::PATTERN_LIMIT) begin
					rd_d = pattern;
				end else begin
					rd_d  = item_s1.cart_data;
					fwd_d = 1'b1;
				end
			end
			default: begin
				rd_d  = 8'd0;
				fwd_d = 1'b0;
			end
		endcase
	end

	// menu registers, updated as the access moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			game_q    <= 1'b0;
			enable_q  <= '0;
			compare_q <= '0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				addr_q[i] <= 16'hFFFF;
				cmpb_q[i] <= 8'd0;
				repb_q[i] <= 8'd0;
			end
		end else if (advance && menu_wr) begin
			game_q <= game_d;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (ctrl_wr) begin
					if (i < rrp_pkg::CTRL_ENTRIES) begin
						compare_q[i] <= item_s1.write_data[1 + i];
						enable_q[i]  <= !item_s1.write_data[4 + i];
					end else begin
						compare_q[i] <= 1'b0;
						enable_q[i]  <= 1'b0;
					end
				end else if (offset <= MaxOffset && offset_m1[11:2] == 10'(i)) begin
					case (offset_m1[1:0])
						2'd0:    addr_q[i][14:8] <= item_s1.write_data[6:0];
						2'd1:    addr_q[i][7:0]  <= item_s1.write_data;
						2'd2:    cmpb_q[i]       <= item_s1.write_data;
						default: repb_q[i]       <= item_s1.write_data;
					endcase
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stage_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rd_d;
			forward_q   <= fwd_d;
			mode_q      <= game_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, mode_q, forward_q, read_data_q};

`ifndef SYNTHESIS
	a_mode_only_on_menu_write: assert property (@(posedge clk) disable iff (!arst_n)
		game_q != $past(game_q) |-> $past(advance && ctrl_wr))
		else $error("mode changed without a control write");

	a_mode_reported: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> mode_q == game_q)
		else $error("reported mode differs from device mode");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.action == rrp_pkg::ACT_CPU_WRITE |=> read_data_q == 8'd0)
		else $error("write returned nonzero read data");

	a_menu_read_local: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !game_q && item_s1.action == rrp_pkg::ACT_CPU_READ
		&& item_s1.address[15] |=> !forward_q && read_data_q == $past(item_s1.menu_rom_data))
		else $error("menu ROM read not served locally");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");
`endif

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rom_read_patch_device
// Loads patch entries and works the control register in menu mode, then
// switches to game mode and hammers the entry addresses with reads. Every
// access is run through a behavioral predictor, and each result transfer is
// compared with the oldest prediction. Both stream sides idle and stall at
// random.
// ----------------------------------------------------------------------------
typedef struct packed {
	bit       mode;
	bit       fwd;
	bit [7:0] rdata;
} access_result_t;

localparam logic [1:0] ACT_UNUSED = 2'd3;

class patch_scoreboard;
	bit             game_on;
	bit             ent_on[rrp_pkg::CTRL_ENTRIES];
	bit             ent_cmp_on[rrp_pkg::CTRL_ENTRIES];
	bit [15:0]      ent_addr[rrp_pkg::CTRL_ENTRIES];
	bit [7:0]       ent_match_byte[rrp_pkg::CTRL_ENTRIES];
	bit [7:0]       ent_subst_byte[rrp_pkg::CTRL_ENTRIES];
	access_result_t expected_q[$];
	int             errors;
	int             results_seen;

	function new();
		game_on = 0;
		for (int i = 0; i < rrp_pkg::CTRL_ENTRIES; i++) begin
			ent_on[i] = 0;
			ent_cmp_on[i] = 0;
			ent_addr[i] = 16'hFFFF;
			ent_match_byte[i] = 8'h00;
			ent_subst_byte[i] = 8'h00;
		end
		errors = 0;
		results_seen = 0;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	task report(string msg);
		errors++;
		$display("ERROR: result %0d: %s", results_seen, msg);
	endtask

	// 2-bit tile pattern; address bit 2 picks which pair of address bits is used
	function bit [7:0] tile_pattern(bit [15:0] a);
		bit hi;
		bit lo;
		hi = a[2] ? a[4] : a[6];
		lo = a[2] ? a[5] : a[7];
		return {{4{hi}}, {4{lo}}};
	endfunction

	function void load_register(bit [11:0] off, bit [7:0] v);
		int idx;
		if (off == rrp_pkg::CTRL_OFFSET) begin
			game_on = v[0];
			for (int i = 0; i < rrp_pkg::CTRL_ENTRIES; i++) begin
				ent_cmp_on[i] = v[1 + i];
				ent_on[i] = !v[4 + i];
			end
		end else if (off <= 4 * rrp_pkg::CTRL_ENTRIES) begin
			idx = (off - 1) >> 2;
			case ((off - 1) & 3)
				0: ent_addr[idx][14:8] = v[6:0];
				1: ent_addr[idx][7:0] = v;
				2: ent_match_byte[idx] = v;
				default: ent_subst_byte[idx] = v;
			endcase
		end
	endfunction

	// entries are applied in order; a later entry sees the byte an earlier one left
	function bit [7:0] patched_byte(rrp_pkg::item_t it);
		bit [7:0] v;
		v = it.cart_data;
		for (int i = 0; i < rrp_pkg::CTRL_ENTRIES; i++) begin
			if (ent_on[i] && ent_addr[i] == it.address &&
					(!ent_cmp_on[i] || v == ent_match_byte[i])) begin
				v = ent_subst_byte[i];
				if (it.address >= rrp_pkg::AND_BASE && it.low_region_readable)
					v &= it.low_region_data;
			end
		end
		return v;
	endfunction

	function void note_access(rrp_pkg::item_t it);
		access_result_t r;
		r = '0;
		case (it.action)
			rrp_pkg::ACT_CPU_READ: begin
				if (it.address < rrp_pkg::PRG_BASE) begin
					r.rdata = it.cart_data;
					r.fwd = 1;
				end else if (!game_on) begin
					r.rdata = it.menu_rom_data;
				end else begin
					r.rdata = patched_byte(it);
					r.fwd = 1;
				end
			end
			rrp_pkg::ACT_CPU_WRITE: begin
				if (!game_on && it.address >= rrp_pkg::PRG_BASE)
					load_register(it.address[11:0], it.write_data);
				else
					r.fwd = 1;
			end
			rrp_pkg::ACT_PPU_READ: begin
				if (!game_on && it.address < rrp_pkg::PATTERN_LIMIT) begin
					r.rdata = tile_pattern(it.address);
				end else begin
					r.rdata = it.cart_data;
					r.fwd = 1;
				end
			end
			default: ;
		endcase
		r.mode = game_on;
		expected_q.push_back(r);
	endfunction

	task check_result(logic [15:0] tdata);
		access_result_t exp;
		if (expected_q.size() == 0) begin
			report($sformatf("unexpected result %h", tdata));
		end else begin
			exp = expected_q.pop_front();
			if (tdata[7:0] !== exp.rdata)
				report($sformatf("read_data %h, expected %h", tdata[7:0], exp.rdata));
			if (tdata[8] !== exp.fwd)
				report($sformatf("forward_write %b, expected %b", tdata[8], exp.fwd));
			if (tdata[9] !== exp.mode)
				report($sformatf("in_game_mode %b, expected %b", tdata[9], exp.mode));
		end
		results_seen++;
	endtask
endclass

module testbench;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	patch_scoreboard sb = new();
	int          idle_max;
	int unsigned cycle_count;

	rom_read_patch_device u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic rrp_pkg::item_t any_access();
		rrp_pkg::item_t it;
		it.action = rrp_pkg::action_t'($urandom_range(0, 2));
		if ($urandom_range(0, 39) == 0)
			it.action = rrp_pkg::action_t'(ACT_UNUSED);
		it.address = 16'($urandom);
		it.write_data = 8'($urandom);
		it.cart_data = 8'($urandom);
		it.menu_rom_data = 8'($urandom);
		it.low_region_data = 8'($urandom);
		it.low_region_readable = 1'($urandom);
		return it;
	endfunction

	function automatic rrp_pkg::item_t reg_write(bit [11:0] off, bit [7:0] data);
		rrp_pkg::item_t it;
		it = any_access();
		it.action = rrp_pkg::ACT_CPU_WRITE;
		it.address = {1'b1, 3'($urandom), off};
		it.write_data = data;
		return it;
	endfunction

	function automatic rrp_pkg::item_t bus_access(rrp_pkg::action_t act, bit [15:0] addr);
		rrp_pkg::item_t it;
		it = any_access();
		it.action = act;
		it.address = addr;
		return it;
	endfunction

	// starts and ends at a falling edge
	task send_access(rrp_pkg::item_t it);
		int gap;
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			s_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {7'b0, it.low_region_readable, it.low_region_data, it.menu_rom_data,
			it.cart_data, it.write_data, it.address};
		s_tuser = it.action;
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
		sb.note_access(it);
		@(negedge clk);
	endtask

	task drain_results();
		s_tvalid = 0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// result side
	initial begin
		int stall;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, idle_max);
			@(negedge clk);
			if (stall > 0) begin
				m_tready = 0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		rrp_pkg::item_t it;
		int    r;
		int    k;
		bit [15:0] target;
		bit [7:0]  ctrl;

		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		idle_max = 6;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// menu mode, directed
		it = bus_access(rrp_pkg::ACT_CPU_READ, 16'h0000); it.cart_data = 8'hFF;
		send_access(it);
		it = bus_access(rrp_pkg::ACT_CPU_READ, 16'h7FFF); it.cart_data = 8'h00;
		send_access(it);
		it = bus_access(rrp_pkg::ACT_CPU_READ, 16'h8000); it.menu_rom_data = 8'hA5;
		send_access(it);
		it = bus_access(rrp_pkg::ACT_CPU_READ, 16'hFFFF); it.menu_rom_data = 8'hFF;
		send_access(it);
		send_access(bus_access(rrp_pkg::ACT_PPU_READ, 16'h0000));
		send_access(bus_access(rrp_pkg::ACT_PPU_READ, 16'h1FFF));
		send_access(bus_access(rrp_pkg::ACT_PPU_READ, 16'h00F4));
		send_access(bus_access(rrp_pkg::ACT_PPU_READ, 16'h00C0));
		send_access(bus_access(rrp_pkg::ACT_PPU_READ, 16'h2000));
		send_access(bus_access(rrp_pkg::ACT_CPU_WRITE, 16'h7FFF));
		send_access(reg_write(12'h001, 8'hFF));
		send_access(reg_write(12'h002, 8'h00));
		send_access(reg_write(12'h003, 8'h5A));
		send_access(reg_write(12'h004, 8'hC3));
		send_access(reg_write(12'h00D, 8'hFF));
		send_access(reg_write(12'hFFF, 8'hFF));
		send_access(bus_access(rrp_pkg::action_t'(ACT_UNUSED), 16'h8001));
		send_access(reg_write(rrp_pkg::CTRL_OFFSET, 8'h0E));
		send_access(bus_access(rrp_pkg::ACT_CPU_READ, 16'hFF00));
		send_access(reg_write(rrp_pkg::CTRL_OFFSET, 8'hF0));

		// menu mode, random register traffic and reads
		for (int n = 0; n < 300; n++) begin
			if (n % 50 == 0)
				idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
			if (n == 150)
				drain_results();
			r = $urandom_range(0, 9);
			if (r < 4) begin
				it = reg_write(($urandom_range(0, 15) == 0) ? 12'($urandom) :
					12'($urandom_range(0, 4 * rrp_pkg::CTRL_ENTRIES)), 8'($urandom));
			end else if (r < 6) begin
				it = bus_access(rrp_pkg::ACT_CPU_READ, 16'($urandom));
			end else if (r < 8) begin
				it = bus_access(rrp_pkg::ACT_PPU_READ,
					(r == 6) ? 16'($urandom_range(0, 16'h1FFF)) : 16'($urandom));
			end else begin
				it = any_access();
			end
			// game mode is entered only at the planned point
			if (it.action == rrp_pkg::ACT_CPU_WRITE && it.address >= rrp_pkg::PRG_BASE &&
					it.address[11:0] == rrp_pkg::CTRL_OFFSET)
				it.write_data[0] = 1'b0;
			send_access(it);
		end

		// sender holds off until the device has answered everything
		drain_results();
		idle_max = 6;

		// program all entries, then switch to game mode
		for (int i = 0; i < rrp_pkg::CTRL_ENTRIES; i++) begin
			case ($urandom_range(0, 4))
				0: target = rrp_pkg::AND_BASE;
				1: target = rrp_pkg::AND_BASE - 16'd1;
				2: target = (i > 0) ? sb.ent_addr[i - 1] : 16'hFFFF;
				3: target = rrp_pkg::PRG_BASE;
				default: target = 16'($urandom);
			endcase
			send_access(reg_write(12'(4 * i + 1), {1'($urandom), target[14:8]}));
			send_access(reg_write(12'(4 * i + 2), target[7:0]));
			send_access(reg_write(12'(4 * i + 3), 8'($urandom)));
			send_access(reg_write(12'(4 * i + 4), 8'($urandom)));
		end
		ctrl = 8'($urandom);
		ctrl[0] = 1'b1;
		for (int i = 0; i < rrp_pkg::CTRL_ENTRIES; i++)
			ctrl[4 + i] = ($urandom_range(0, 3) == 0);
		send_access(reg_write(rrp_pkg::CTRL_OFFSET, ctrl));

		// game mode, directed
		for (int i = 0; i < rrp_pkg::CTRL_ENTRIES; i++) begin
			it = bus_access(rrp_pkg::ACT_CPU_READ, sb.ent_addr[i]);
			it.cart_data = sb.ent_match_byte[i];
			it.low_region_readable = 1'b1;
			send_access(it);
			it.cart_data = ~sb.ent_match_byte[i];
			it.low_region_readable = 1'b0;
			send_access(it);
		end
		it = reg_write(rrp_pkg::CTRL_OFFSET, 8'h00); send_access(it);
		send_access(bus_access(rrp_pkg::ACT_PPU_READ, 16'h0000));
		send_access(bus_access(rrp_pkg::ACT_CPU_READ, 16'h7FFF));
		send_access(bus_access(rrp_pkg::action_t'(ACT_UNUSED), 16'hC020));

		// game mode, random reads aimed at the entries
		for (int n = 0; n < 420; n++) begin
			if (n % 50 == 0)
				idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
			if ($urandom_range(0, 9) < 7) begin
				k = $urandom_range(0, rrp_pkg::CTRL_ENTRIES - 1);
				case ($urandom_range(0, 3))
					0, 1: target = sb.ent_addr[k];
					2: target = $urandom_range(0, 1) ? sb.ent_addr[k] + 16'd1 :
						sb.ent_addr[k] - 16'd1;
					default: target = {1'b1, 15'($urandom)};
				endcase
				it = bus_access(rrp_pkg::ACT_CPU_READ, target);
				if ($urandom_range(0, 1))
					it.cart_data =
						sb.ent_match_byte[$urandom_range(0, rrp_pkg::CTRL_ENTRIES - 1)];
			end else begin
				it = any_access();
			end
			send_access(it);
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (sb.pending() != 0)
			sb.report("expected results left over");
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
